// File: hw/rtl/plvc_pkg.sv
// Shared types, constants and helpers of the pairwise LDA vote classifier.
package plvc_pkg;

    // Sizes of the classifier
    localparam int MAX_CLASSES  = 8;
    localparam int NUM_FEATURES = 6;
    localparam int WEIGHT_WIDTH = 16;
    localparam int MAX_PAIRS    = (MAX_CLASSES * (MAX_CLASSES - 1)) / 2;

    // Port field widths
    localparam int ACTION_W      = 2;
    localparam int PAIR_W        = 5;
    localparam int SLOT_W        = 3;
    localparam int LOAD_W        = 40;
    localparam int FEAT_W        = 16;
    localparam int CFG_W         = 4;
    localparam int OUT_CLASS_W   = 3;
    localparam int OUT_VOTE_W    = 4;

    // Internal widths
    localparam int CLASS_W  = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int NCLS_W   = $clog2(MAX_CLASSES + 1);
    localparam int VOTE_W   = $clog2(MAX_CLASSES) + 1;
    localparam int PROD_W   = FEAT_W + WEIGHT_WIDTH;
    localparam int PROJ_W   = PROD_W + $clog2(NUM_FEATURES + 1);
    localparam int DIFF_W   = ((PROJ_W > LOAD_W) ? PROJ_W : LOAD_W) + 1;
    localparam int TREE_LVL = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int LEAVES   = 1 << TREE_LVL;

    // Cycles from pair address to registered distance decision
    localparam int DEC_LAT = 5;

    // Action codes
    localparam logic [ACTION_W-1:0] ACTION_LOAD_WEIGHT = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_LOAD_MEAN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_CLASSIFY    = 2'd2;

    // Saturation bounds of a weight, in load-value width
    localparam logic signed [LOAD_W-1:0] WEIGHT_MAX =
        LOAD_W'((64'sd1 <<< (WEIGHT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [LOAD_W-1:0] WEIGHT_MIN = -WEIGHT_MAX - LOAD_W'(1);

    typedef logic signed [WEIGHT_WIDTH-1:0] t_weight;
    typedef logic signed [FEAT_W-1:0]       t_feature;
    typedef logic signed [PROD_W-1:0]       t_prod;
    typedef logic signed [LOAD_W-1:0]       t_mean;

    // Pair tag that rides along the datapath
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [CLASS_W-1:0] cls_i;
        logic [CLASS_W-1:0] cls_j;
    } t_tag;

    // Vote update: tag plus distance decision (mean 0 strictly nearer)
    typedef struct packed {
        t_tag tag;
        logic near0;
    } t_vote_upd;

    // Argmax candidate
    typedef struct packed {
        logic                      ok;
        logic [CLASS_W-1:0]        idx;
        logic signed [VOTE_W-1:0]  votes;
    } t_cand;

    // Final answer of the vote stage
    typedef struct packed {
        logic                      valid;
        logic [CLASS_W-1:0]        cls;
        logic signed [VOTE_W-1:0]  votes;
    } t_result;

    // Clamp a load value into the weight range
    function automatic t_weight sat_weight(input t_mean v);
        t_mean c;
        begin
            c = v;
            if (v > WEIGHT_MAX) c = WEIGHT_MAX;
            if (v < WEIGHT_MIN) c = WEIGHT_MIN;
            sat_weight = t_weight'(c);
        end
    endfunction

    // Clamp the class count into [2, MAX_CLASSES]
    function automatic logic [NCLS_W-1:0] sat_classes(input logic [CFG_W-1:0] n);
        logic [NCLS_W-1:0] r;
        begin
            if (32'(n) < 2)                r = NCLS_W'(2);
            else if (32'(n) > MAX_CLASSES) r = NCLS_W'(MAX_CLASSES);
            else                           r = NCLS_W'(n);
            sat_classes = r;
        end
    endfunction

    // Keep a unless b is valid and either a is not or b is strictly higher (lower index wins ties)
    function automatic t_cand pick_cand(input t_cand a, input t_cand b);
        begin
            if (b.ok && (!a.ok || (b.votes > a.votes))) pick_cand = b;
            else                                         pick_cand = a;
        end
    endfunction

endpackage

// File: hw/rtl/plvc_lane.sv
// One feature lane: per-pair weight memory and a registered multiply.
module plvc_lane (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [plvc_pkg::PAIR_W-1:0]  i_wr_addr,
    input  plvc_pkg::t_weight            i_wr_data,
    input  logic [plvc_pkg::PAIR_W-1:0]  i_rd_addr,
    input  plvc_pkg::t_feature           i_feature,
    output plvc_pkg::t_prod              o_prod
);
    import plvc_pkg::*;

    t_weight r_mem [MAX_PAIRS];
    t_weight r_weight;
    t_prod   r_prod;

    // Weight memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_weight <= r_mem[i_rd_addr];
    end

    // Feature times weight, exact
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_feature) * PROD_W'(r_weight);
    end

    assign o_prod = r_prod;

endmodule

// File: hw/rtl/plvc_merge.sv
// Merge stage: sums lane products, compares distances to the pair's two means.
module plvc_merge (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic                         i_wr_sel,
    input  logic [plvc_pkg::PAIR_W-1:0]  i_wr_addr,
    input  plvc_pkg::t_mean              i_wr_data,
    input  logic [plvc_pkg::PAIR_W-1:0]  i_rd_addr,
    input  plvc_pkg::t_prod              i_prod [plvc_pkg::NUM_FEATURES],
    output logic                         o_near0
);
    import plvc_pkg::*;

    t_mean r_mean0_mem [MAX_PAIRS];
    t_mean r_mean1_mem [MAX_PAIRS];
    t_mean r_mean0_rd, r_mean1_rd;
    t_mean r_mean0_d,  r_mean1_d;
    t_mean r_mean0_s,  r_mean1_s;

    logic signed [PROJ_W-1:0] w_sum;
    logic signed [PROJ_W-1:0] r_proj;
    logic signed [DIFF_W-1:0] r_diff0, r_diff1;
    logic        [DIFF_W-1:0] w_abs0, w_abs1;
    logic                     r_near0;

    // Mean memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_sel) begin
            r_mean0_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && i_wr_sel) begin
            r_mean1_mem[i_wr_addr] <= i_wr_data;
        end
        r_mean0_rd <= r_mean0_mem[i_rd_addr];
        r_mean1_rd <= r_mean1_mem[i_rd_addr];
    end

    // Adder tree over the lanes
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_FEATURES; k++) begin
            w_sum = w_sum + PROJ_W'(i_prod[k]);
        end
    end

    // Align means with products, then projection, then differences
    always_ff @(posedge i_clk) begin
        r_mean0_d <= r_mean0_rd;
        r_mean1_d <= r_mean1_rd;
        r_mean0_s <= r_mean0_d;
        r_mean1_s <= r_mean1_d;
        r_proj    <= w_sum;
        r_diff0   <= DIFF_W'(r_proj) - DIFF_W'(r_mean0_s);
        r_diff1   <= DIFF_W'(r_proj) - DIFF_W'(r_mean1_s);
    end

    // Absolute distances and strict compare
    assign w_abs0 = r_diff0[DIFF_W-1] ? DIFF_W'(-r_diff0) : DIFF_W'(r_diff0);
    assign w_abs1 = r_diff1[DIFF_W-1] ? DIFF_W'(-r_diff1) : DIFF_W'(r_diff1);

    always_ff @(posedge i_clk) begin
        r_near0 <= (w_abs0 < w_abs1);
    end

    assign o_near0 = r_near0;

endmodule

// File: hw/rtl/plvc_vote.sv
// Vote counters per class and a registered argmax tree over them.
module plvc_vote (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  plvc_pkg::t_vote_upd          i_upd,
    input  logic [plvc_pkg::NCLS_W-1:0]  i_ncls,
    output plvc_pkg::t_result            o_result
);
    import plvc_pkg::*;

    logic signed [VOTE_W-1:0] r_votes [MAX_CLASSES];
    logic signed [VOTE_W-1:0] w_delta [MAX_CLASSES];
    t_cand                    w_leaf  [LEAVES];
    t_cand                    w_in_a  [1:LEAVES-1];
    t_cand                    w_in_b  [1:LEAVES-1];
    t_cand                    r_node  [1:LEAVES-1];
    logic                     r_final;
    logic [TREE_LVL-1:0]      r_tvld;

    // Per-class step: winner of the pair +1, loser -1
    always_comb begin
        for (int k = 0; k < MAX_CLASSES; k++) begin
            w_delta[k] = '0;
            if (i_upd.tag.cls_i == CLASS_W'(k)) begin
                w_delta[k] = i_upd.near0 ? VOTE_W'(1) : -VOTE_W'(1);
            end
            if (i_upd.tag.cls_j == CLASS_W'(k)) begin
                w_delta[k] = i_upd.near0 ? -VOTE_W'(1) : VOTE_W'(1);
            end
        end
    end

    // Counters, cleared at each classify
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_CLASSES; k++) begin
            if (i_clear) begin
                r_votes[k] <= '0;
            end else if (i_upd.tag.valid) begin
                r_votes[k] <= r_votes[k] + w_delta[k];
            end
        end
    end

    // Tree leaves; classes beyond the count in use drop out
    for (genvar gk = 0; gk < LEAVES; gk++) begin : g_leaf
        if (gk < MAX_CLASSES) begin : g_used
            assign w_leaf[gk].ok    = (NCLS_W'(gk) < i_ncls);
            assign w_leaf[gk].idx   = CLASS_W'(gk);
            assign w_leaf[gk].votes = r_votes[gk];
        end else begin : g_pad
            assign w_leaf[gk] = '0;
        end
    end

    // Heap-ordered tree wiring: node k has children 2k and 2k+1
    for (genvar gn = 1; gn < LEAVES; gn++) begin : g_node
        if (2 * gn >= LEAVES) begin : g_bottom
            assign w_in_a[gn] = w_leaf[2 * gn - LEAVES];
            assign w_in_b[gn] = w_leaf[2 * gn + 1 - LEAVES];
        end else begin : g_inner
            assign w_in_a[gn] = r_node[2 * gn];
            assign w_in_b[gn] = r_node[2 * gn + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k < LEAVES; k++) begin
            r_node[k] <= pick_cand(w_in_a[k], w_in_b[k]);
        end
    end

    // Tree timing: start after the last pair's update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final <= 1'b0;
            r_tvld  <= '0;
        end else begin
            r_final <= i_upd.tag.valid && i_upd.tag.last;
            if (TREE_LVL > 1) begin
                r_tvld <= {r_tvld[TREE_LVL-2:0], r_final};
            end else begin
                r_tvld <= TREE_LVL'(r_final);
            end
        end
    end

    assign o_result.valid = r_tvld[TREE_LVL-1];
    assign o_result.cls   = r_node[1].idx;
    assign o_result.votes = r_node[1].votes;

endmodule

// File: hw/rtl/pairwise_lda_vote_classifier_unit.sv
// Top level of the pairwise LDA vote classifier: sequencer, lanes, merge, votes.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------------------
//  item in   | i_start & !o_busy     | i_action, i_pair_index, i_slot_index,
//            |                       | i_load_value, i_feature_0 .. i_feature_5
//  result    | o_done (one cycle)    | o_predicted_class, o_winning_votes
//  config    | i_cfg_we              | i_cfg_wdata (num_classes)
//
// Load items finish at the accepting edge; busy stays low.
// A classify item holds busy while it walks P = n(n-1)/2 pairs (28 for eight classes):
// one pair per cycle through the six multiplier lanes, then the weight read, product,
// projection, difference and decision registers, the vote counter update, then a
// three-level registered argmax tree. The result strobe is in the last busy cycle.
// Reset (synchronous, active low) clears control state and sets eight classes;
// the weight and mean memories are not cleared. The receiver cannot stall.
module pairwise_lda_vote_classifier_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [plvc_pkg::ACTION_W-1:0]         i_action,
    input  logic [plvc_pkg::PAIR_W-1:0]           i_pair_index,
    input  logic [plvc_pkg::SLOT_W-1:0]           i_slot_index,
    input  logic signed [plvc_pkg::LOAD_W-1:0]    i_load_value,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_0,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_1,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_2,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_3,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_4,
    input  logic signed [plvc_pkg::FEAT_W-1:0]    i_feature_5,
    input  logic                                  i_cfg_we,
    input  logic [plvc_pkg::CFG_W-1:0]            i_cfg_wdata,
    output logic                                  o_done,
    output logic [plvc_pkg::OUT_CLASS_W-1:0]      o_predicted_class,
    output logic signed [plvc_pkg::OUT_VOTE_W-1:0] o_winning_votes
);
    import plvc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_num_classes;
    logic [NCLS_W-1:0]   r_ncls;
    t_feature            r_feat [NUM_FEATURES];
    t_feature            w_feat [NUM_FEATURES];
    logic [CLASS_W-1:0]  r_i, r_j;
    logic [PAIR_W-1:0]   r_pair;
    t_tag                r_tag [DEC_LAT];
    t_tag                w_issue;
    logic                w_accept, w_classify, w_last;
    logic                w_load_w, w_load_m;
    t_weight             w_wr_weight;
    t_prod               w_prod [NUM_FEATURES];
    logic                w_near0;
    t_vote_upd           w_upd;
    t_result             w_res;

    assign w_feat[0] = i_feature_0;
    assign w_feat[1] = i_feature_1;
    assign w_feat[2] = i_feature_2;
    assign w_feat[3] = i_feature_3;
    assign w_feat[4] = i_feature_4;
    assign w_feat[5] = i_feature_5;

    // Item acceptance and load decode
    assign o_busy     = (r_state != ST_IDLE);
    assign w_accept   = i_start && !o_busy;
    assign w_classify = w_accept && (i_action == ACTION_CLASSIFY);
    assign w_load_w   = w_accept && (i_action == ACTION_LOAD_WEIGHT)
                        && (32'(i_pair_index) < MAX_PAIRS)
                        && (32'(i_slot_index) < NUM_FEATURES);
    assign w_load_m   = w_accept && (i_action == ACTION_LOAD_MEAN)
                        && (32'(i_pair_index) < MAX_PAIRS)
                        && (32'(i_slot_index) < 2);
    assign w_wr_weight = sat_weight(i_load_value);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= CFG_W'(MAX_CLASSES);
        end else if (i_cfg_we) begin
            r_num_classes <= i_cfg_wdata;
        end
    end

    // Last pair: i is the second-to-last class in use
    assign w_last = (NCLS_W'(r_i) + NCLS_W'(2) == r_ncls);

    // Pair sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_classify) begin
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_res.valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Sample, class count and pair walk
    always_ff @(posedge i_clk) begin
        if (w_classify) begin
            r_ncls <= sat_classes(r_num_classes);
            r_feat <= w_feat;
            r_i    <= '0;
            r_j    <= CLASS_W'(1);
            r_pair <= '0;
        end else if (r_state == ST_ISSUE) begin
            r_pair <= r_pair + PAIR_W'(1);
            if (NCLS_W'(r_j) + NCLS_W'(1) == r_ncls) begin
                r_i <= r_i + CLASS_W'(1);
                r_j <= r_i + CLASS_W'(2);
            end else begin
                r_j <= r_j + CLASS_W'(1);
            end
        end
    end

    // Tag pipeline matched to the datapath latency
    assign w_issue.valid = (r_state == ST_ISSUE);
    assign w_issue.last  = w_last;
    assign w_issue.cls_i = r_i;
    assign w_issue.cls_j = r_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEC_LAT; k++) begin
                r_tag[k] <= '0;
            end
        end else begin
            r_tag[0] <= w_issue;
            for (int k = 1; k < DEC_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // Feature lanes
    for (genvar gl = 0; gl < NUM_FEATURES; gl++) begin : g_lane
        plvc_lane u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (w_load_w && (i_slot_index == SLOT_W'(gl))),
            .i_wr_addr (i_pair_index),
            .i_wr_data (w_wr_weight),
            .i_rd_addr (r_pair),
            .i_feature (r_feat[gl]),
            .o_prod    (w_prod[gl])
        );
    end

    // Projection and distance decision
    plvc_merge u_merge (
        .i_clk     (i_clk),
        .i_wr_en   (w_load_m),
        .i_wr_sel  (i_slot_index[0]),
        .i_wr_addr (i_pair_index),
        .i_wr_data (i_load_value),
        .i_rd_addr (r_pair),
        .i_prod    (w_prod),
        .o_near0   (w_near0)
    );

    assign w_upd.tag   = r_tag[DEC_LAT-1];
    assign w_upd.near0 = w_near0;

    // Votes and argmax
    plvc_vote u_vote (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_classify),
        .i_upd    (w_upd),
        .i_ncls   (r_ncls),
        .o_result (w_res)
    );

    assign o_done            = w_res.valid;
    assign o_predicted_class = OUT_CLASS_W'(w_res.cls);
    assign o_winning_votes   = OUT_VOTE_W'(w_res.votes);

endmodule

// File: hw/rtl/plvc_checker.sv
// Port-level checker for the pairwise LDA vote classifier, bound to the top level.
module plvc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_start,
    input logic                                   o_busy,
    input logic [plvc_pkg::ACTION_W-1:0]          i_action,
    input logic                                   o_done,
    input logic signed [plvc_pkg::OUT_VOTE_W-1:0] o_winning_votes
);
    import plvc_pkg::*;

    // A classify item makes the block busy
    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == ACTION_CLASSIFY) |=> o_busy)
        else $error("classify item did not raise busy");

    // Other items complete at once
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action != ACTION_CLASSIFY) |=> !o_busy)
        else $error("non-classify item raised busy");

    // A result ends the busy period
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_busy ##1 !o_busy))
        else $error("result strobe not at end of busy period");

    // Busy drops only after a result
    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> $past(o_done))
        else $error("busy dropped without a result");

    // Votes sum to zero, so the top total is never negative
    a_votes_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_winning_votes[OUT_VOTE_W-1])
        else $error("winning vote total negative");

endmodule

bind pairwise_lda_vote_classifier_unit plvc_checker u_plvc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .i_action        (i_action),
    .o_done          (o_done),
    .o_winning_votes (o_winning_votes)
);
